>>> src/dbsa_pkg.sv
// Package for the deformable bilinear scatter-accumulate block: types, constants and codes.
package dbsa_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int MAX_ROWS     = 64;
  localparam int MAX_COLS     = 64;
  localparam int CH_BITS      = $clog2(MAX_CHANNELS);
  localparam int ROW_BITS     = $clog2(MAX_ROWS);
  localparam int COL_BITS     = $clog2(MAX_COLS);
  localparam int ADDR_BITS    = CH_BITS + ROW_BITS + COL_BITS;
  localparam int STORE_DEPTH  = MAX_CHANNELS * MAX_ROWS * MAX_COLS;
  localparam int WORD_BITS    = 33;  // clip mark and 32-bit accumulator
  localparam int MAC_A_BITS   = 28;
  localparam int MAC_B_BITS   = 17;
  localparam int MAC_P_BITS   = MAC_A_BITS + MAC_B_BITS;

  localparam logic [0:0] OP_SCATTER = 1'b0;
  localparam logic [0:0] OP_READ    = 1'b1;

  localparam logic [2:0] CFG_IMAGE_ROWS   = 3'd0;
  localparam logic [2:0] CFG_IMAGE_COLS   = 3'd1;
  localparam logic [2:0] CFG_ROW_STRIDE   = 3'd2;
  localparam logic [2:0] CFG_COL_STRIDE   = 3'd3;
  localparam logic [2:0] CFG_ROW_PAD      = 3'd4;
  localparam logic [2:0] CFG_COL_PAD      = 3'd5;
  localparam logic [2:0] CFG_ROW_DILATION = 3'd6;
  localparam logic [2:0] CFG_COL_DILATION = 3'd7;

  typedef struct packed {
    logic [0:0]         opcode;
    logic [1:0]         channel;
    logic [5:0]         out_row;
    logic [5:0]         out_col;
    logic [3:0]         tap_row;
    logic [3:0]         tap_col;
    logic signed [15:0] shift_rows;
    logic signed [15:0] shift_cols;
    logic [8:0]         modulation;
    logic signed [15:0] column_value;
    logic [5:0]         read_row;
    logic [5:0]         read_col;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               saturated;
  } out_res_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_GEOM, S_NB, S_M1, S_M2, S_M3, S_RND, S_ACC, S_RD, S_RDOUT
  } state_t;

endpackage

>>> src/deformable_bilinear_scatter_accumulate.sv
// Top level of the deformable bilinear scatter-accumulate block.
//
// Requests enter on in_req and are taken at a rising edge where start is high
// and busy is low. A scatter request (opcode 0) forms the sampling point from
// the stride, padding, dilation and offset, then walks the 3x3 neighbours of
// the truncated point one at a time, testing each in state S_NB. A neighbour
// that receives a contribution then passes through S_M1, S_M2, S_M3, S_RND
// and S_ACC: one shared multiplier forms mask*wy, then *wx, then *value,
// followed by a rounding step and a read-modify-write of the store. At most
// four neighbours of a scatter request qualify.
// A read request (opcode 1) shows the entry on out_res with out_valid high
// for exactly one cycle, and clears it in that same cycle.
// The receiver cannot stall; every result is taken the cycle it appears.
// Configuration writes go through cfg_we, cfg_index and cfg_data and should
// only be issued while the block is idle.
// After reset the block runs a clearing pass over the whole store, one entry
// per cycle, holding busy high; configuration writes are still taken during
// that pass.
module deformable_bilinear_scatter_accumulate
  import dbsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_req_t    in_req,
  output logic       out_valid,
  output out_res_t   out_res,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data
);

  // Configuration registers.
  logic [6:0] image_rows_r, image_cols_r;
  logic [3:0] row_stride_r, col_stride_r, row_pad_r, col_pad_r;
  logic [3:0] row_dilation_r, col_dilation_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_rows_r   <= 7'd64;
      image_cols_r   <= 7'd64;
      row_stride_r   <= 4'd1;
      col_stride_r   <= 4'd1;
      row_pad_r      <= 4'd0;
      col_pad_r      <= 4'd0;
      row_dilation_r <= 4'd1;
      col_dilation_r <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_ROWS:   image_rows_r   <= cfg_data;
        CFG_IMAGE_COLS:   image_cols_r   <= cfg_data;
        CFG_ROW_STRIDE:   row_stride_r   <= cfg_data[3:0];
        CFG_COL_STRIDE:   col_stride_r   <= cfg_data[3:0];
        CFG_ROW_PAD:      row_pad_r      <= cfg_data[3:0];
        CFG_COL_PAD:      col_pad_r      <= cfg_data[3:0];
        CFG_ROW_DILATION: row_dilation_r <= cfg_data[3:0];
        CFG_COL_DILATION: col_dilation_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Control and datapath registers.
  state_t                state_r, state_nxt;
  logic [ADDR_BITS:0]    clr_cnt_r, clr_cnt_nxt;
  in_req_t               req_r, req_nxt;
  logic signed [21:0]    yq_r, yq_nxt, xq_r, xq_nxt;
  logic signed [13:0]    ty_r, ty_nxt, tx_r, tx_nxt;
  logic [1:0]            dy_r, dy_nxt, dx_r, dx_nxt;
  logic [8:0]            wy_r, wy_nxt, wx_r, wx_nxt;
  logic [ADDR_BITS-1:0]  idx_r, idx_nxt;
  logic signed [29:0]    rnd_r, rnd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
    req_r <= req_nxt;
    yq_r  <= yq_nxt;
    xq_r  <= xq_nxt;
    ty_r  <= ty_nxt;
    tx_r  <= tx_nxt;
    dy_r  <= dy_nxt;
    dx_r  <= dx_nxt;
    wy_r  <= wy_nxt;
    wx_r  <= wx_nxt;
    idx_r <= idx_nxt;
    rnd_r <= rnd_nxt;
  end

  // Store and shared multiplier.
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata, mem_rdata;
  logic                  mac_en;
  logic signed [MAC_A_BITS-1:0] mac_a;
  logic signed [MAC_B_BITS-1:0] mac_b;
  logic signed [MAC_P_BITS-1:0] mac_p;

  dbsa_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_r),
    .rdata (mem_rdata)
  );

  dbsa_mac u_mac (
    .clk    (clk),
    .en     (mac_en),
    .op_a   (mac_a),
    .op_b   (mac_b),
    .prod_r (mac_p)
  );

  // Geometry of the sampling point, from the captured request.
  logic signed [12:0] base_y, base_x;
  logic signed [21:0] yq_calc, xq_calc;
  assign base_y = $signed({3'b0, 10'(req_r.out_row * row_stride_r)})
                + $signed({5'b0, 8'(req_r.tap_row * row_dilation_r)})
                - $signed({9'b0, row_pad_r});
  assign base_x = $signed({3'b0, 10'(req_r.out_col * col_stride_r)})
                + $signed({5'b0, 8'(req_r.tap_col * col_dilation_r)})
                - $signed({9'b0, col_pad_r});
  assign yq_calc = $signed({base_y, 8'b0}) + 22'(req_r.shift_rows);
  assign xq_calc = $signed({base_x, 8'b0}) + 22'(req_r.shift_cols);

  // Neighbour test for the current (dy, dx).
  logic signed [14:0] nr, nc;
  logic signed [23:0] ey_s, ex_s;
  logic [23:0]        ey, ex;
  logic [6:0]         lim_r, lim_c;
  logic               nb_ok;
  assign nr    = 15'(ty_r) + 15'($signed({1'b0, dy_r})) - 15'sd1;
  assign nc    = 15'(tx_r) + 15'($signed({1'b0, dx_r})) - 15'sd1;
  assign ey_s  = 24'(yq_r) - $signed({nr, 8'b0}) ;
  assign ex_s  = 24'(xq_r) - $signed({nc, 8'b0});
  assign ey    = ey_s < 0 ? 24'(-ey_s) : 24'(ey_s);
  assign ex    = ex_s < 0 ? 24'(-ex_s) : 24'(ex_s);
  assign lim_r = image_rows_r < 7'(MAX_ROWS) ? image_rows_r : 7'(MAX_ROWS);
  assign lim_c = image_cols_r < 7'(MAX_COLS) ? image_cols_r : 7'(MAX_COLS);
  assign nb_ok = (nr >= 0) && (nr < $signed({8'b0, lim_r}))
              && (nc >= 0) && (nc < $signed({8'b0, lim_c}))
              && (ey < 24'd256) && (ex < 24'd256);

  // Rounding of the Q.32 product to Q16.16, ties away from zero.
  logic [MAC_P_BITS-1:0] pmag;
  logic [MAC_P_BITS-1:0] pmag_rnd;
  assign pmag     = mac_p < 0 ? MAC_P_BITS'(-mac_p) : MAC_P_BITS'(mac_p);
  assign pmag_rnd = (pmag + MAC_P_BITS'(32768)) >> 16;

  // Saturating accumulate.
  logic signed [33:0] acc_sum;
  logic signed [31:0] acc_val;
  logic               acc_clip;
  assign acc_sum = 34'($signed(mem_rdata[31:0])) + 34'(rnd_r);
  always_comb begin
    acc_clip = 1'b1;
    if (acc_sum > 34'sd2147483647) begin
      acc_val = 32'h7FFF_FFFF;
    end else if (acc_sum < -34'sd2147483648) begin
      acc_val = 32'h8000_0000;
    end else begin
      acc_val  = acc_sum[31:0];
      acc_clip = 1'b0;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    req_nxt     = req_r;
    yq_nxt      = yq_r;
    xq_nxt      = xq_r;
    ty_nxt      = ty_r;
    tx_nxt      = tx_r;
    dy_nxt      = dy_r;
    dx_nxt      = dx_r;
    wy_nxt      = wy_r;
    wx_nxt      = wx_r;
    idx_nxt     = idx_r;
    rnd_nxt     = rnd_r;
    busy        = 1'b1;
    out_valid   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx_r;
    mem_wdata   = '0;
    mac_en      = 1'b0;
    mac_a       = '0;
    mac_b       = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r[ADDR_BITS-1:0];
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == (ADDR_BITS+1)'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          req_nxt = in_req;
          if (in_req.opcode == OP_READ) begin
            idx_nxt   = {in_req.channel, in_req.read_row, in_req.read_col};
            state_nxt = S_RD;
          end else begin
            state_nxt = S_GEOM;
          end
        end
      end
      S_GEOM: begin
        yq_nxt    = yq_calc;
        xq_nxt    = xq_calc;
        // Truncation toward zero of the Q14.8 point.
        ty_nxt    = yq_calc < 0 ? 14'((yq_calc + 22'sd255) >>> 8) : 14'(yq_calc >>> 8);
        tx_nxt    = xq_calc < 0 ? 14'((xq_calc + 22'sd255) >>> 8) : 14'(xq_calc >>> 8);
        dy_nxt    = 2'd0;
        dx_nxt    = 2'd0;
        state_nxt = S_NB;
      end
      S_NB: begin
        if (nb_ok) begin
          wy_nxt    = 9'(24'd256 - ey);
          wx_nxt    = 9'(24'd256 - ex);
          idx_nxt   = {req_r.channel, nr[ROW_BITS-1:0], nc[COL_BITS-1:0]};
          state_nxt = S_M1;
        end else if (dy_r == 2'd2 && dx_r == 2'd2) begin
          state_nxt = S_IDLE;
        end else if (dx_r == 2'd2) begin
          dx_nxt = 2'd0;
          dy_nxt = dy_r + 2'd1;
        end else begin
          dx_nxt = dx_r + 2'd1;
        end
      end
      S_M1: begin
        mac_en    = 1'b1;
        mac_a     = $signed({19'b0, req_r.modulation});
        mac_b     = $signed({8'b0, wy_r});
        state_nxt = S_M2;
      end
      S_M2: begin
        mac_en    = 1'b1;
        mac_a     = mac_p[MAC_A_BITS-1:0];
        mac_b     = $signed({8'b0, wx_r});
        state_nxt = S_M3;
      end
      S_M3: begin
        mac_en    = 1'b1;
        mac_a     = mac_p[MAC_A_BITS-1:0];
        mac_b     = MAC_B_BITS'(req_r.column_value);
        state_nxt = S_RND;
      end
      S_RND: begin
        rnd_nxt   = mac_p < 0 ? -$signed(30'(pmag_rnd)) : $signed(30'(pmag_rnd));
        state_nxt = S_ACC;
      end
      S_ACC: begin
        mem_we    = 1'b1;
        mem_wdata = {mem_rdata[32] | acc_clip, acc_val};
        if (dy_r == 2'd2 && dx_r == 2'd2) begin
          state_nxt = S_IDLE;
        end else begin
          if (dx_r == 2'd2) begin
            dx_nxt = 2'd0;
            dy_nxt = dy_r + 2'd1;
          end else begin
            dx_nxt = dx_r + 2'd1;
          end
          state_nxt = S_NB;
        end
      end
      S_RD: begin
        state_nxt = S_RDOUT;
      end
      S_RDOUT: begin
        out_valid = 1'b1;
        mem_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_res.read_value = $signed(mem_rdata[31:0]);
  assign out_res.saturated  = mem_rdata[32];

endmodule

>>> src/dbsa_store.sv
// Gradient store memory: one write port and one registered read port.
module dbsa_store
  import dbsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/dbsa_mac.sv
// Shared signed multiplier with a registered product, reused for all weight products.
module dbsa_mac
  import dbsa_pkg::*;
(
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [MAC_A_BITS-1:0] op_a,
  input  logic signed [MAC_B_BITS-1:0] op_b,
  output logic signed [MAC_P_BITS-1:0] prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

endmodule
